>>> sv/abmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abmd_pkg
// Shared types, widths, register codes and pixel arithmetic for the
// adaptive background motion detector.
// ----------------------------------------------------------------------------
package abmd_pkg;

  localparam int CH_W       = 8;
  localparam int X_W        = 10;
  localparam int Y_W        = 9;
  localparam int GAIN_W     = 10;
  localparam int RATE_W     = 8;
  localparam int MOTION_W   = 19;
  localparam int LUM_W      = 28;
  localparam int COUNT_W    = 25;
  localparam int MEAN_W     = 14;
  localparam int DIST_W     = 10;
  localparam int LIMIT_W    = GAIN_W + MEAN_W;
  localparam int DIVIDEND_W = LUM_W + 4;
  localparam int SHIFT_W    = COUNT_W + MEAN_W - 1;
  localparam int STEP_W     = $clog2(MEAN_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOTION_PIXELS = 2'd2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET       = 10'd333;
  localparam logic [RATE_W-1:0]   RATE_RESET       = 8'd5;
  localparam logic [MOTION_W-1:0] MIN_MOTION_RESET = 19'd153;

  localparam logic [LUM_W-1:0]    LUM_MAX    = '1;
  localparam logic [MOTION_W-1:0] MOTION_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [MEAN_W-1:0]   MEAN_MAX   = '1;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } abmd_rgb_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COUNT_W-1:0]    divisor;
  } abmd_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [MEAN_W-1:0] mean;
  } abmd_div_st_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // move background toward pixel by rate/256 of the gap, floored
  function automatic logic [CH_W-1:0] adapt_ch(input logic [CH_W-1:0]   bg,
                                               input logic [CH_W-1:0]   px,
                                               input logic [RATE_W-1:0] rate);
    logic [CH_W-1:0]        gap;
    logic [2*CH_W:0]        step;
    if (px >= bg) begin
      gap  = px - bg;
      step = (2*CH_W+1)'(gap) * (2*CH_W+1)'(rate);
      return bg + step[2*CH_W-1:CH_W];
    end else begin
      gap  = bg - px;
      step = (2*CH_W+1)'(gap) * (2*CH_W+1)'(rate) + (2*CH_W+1)'(255);
      return bg - step[2*CH_W-1:CH_W];
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/abmd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abmd interfaces
// Valid/ready channels for pixel items, result items and register writes.
// ----------------------------------------------------------------------------
interface abmd_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [abmd_pkg::CH_W-1:0]   red;
  logic [abmd_pkg::CH_W-1:0]   green;
  logic [abmd_pkg::CH_W-1:0]   blue;
  logic [abmd_pkg::X_W-1:0]    pixel_x;
  logic [abmd_pkg::Y_W-1:0]    pixel_y;
  logic                        frame_last;

  modport source (output valid, red, green, blue, pixel_x, pixel_y, frame_last,
                  input ready);
  modport sink (input valid, red, green, blue, pixel_x, pixel_y, frame_last,
                output ready);
endinterface

interface abmd_result_if;
  logic                          valid;
  logic                          ready;
  logic                          is_moving;
  logic [abmd_pkg::X_W-1:0]      out_x;
  logic [abmd_pkg::Y_W-1:0]      out_y;
  logic                          frame_done;
  logic                          enough_motion;
  logic [abmd_pkg::MOTION_W-1:0] moving_total;
  logic [abmd_pkg::MEAN_W-1:0]   mean_luminosity;

  modport source (output valid, is_moving, out_x, out_y, frame_done, enough_motion,
                  moving_total, mean_luminosity, input ready);
  modport sink (input valid, is_moving, out_x, out_y, frame_done, enough_motion,
                moving_total, mean_luminosity, output ready);
endinterface

interface abmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [abmd_pkg::CFG_IDX_W-1:0]  index;
  logic [abmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/adaptive_background_motion_detect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_background_motion_detect
// Running-average background subtraction: per-pixel motion flag, background
// update in a frame memory, frame luminosity mean and motion count.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_px     in   valid/ready    red green blue pixel_x pixel_y frame_last
//  out_res   out  valid/ready    is_moving out_x out_y frame_done enough_motion
//                                moving_total mean_luminosity
//  cfg_wr    in   valid/ready    index data (always ready)
//
//  One item per cycle unless the output stalls or the divider is busy; an item
//  passes the pixel stage, then the result register. Its background word is
//  read at accept, written back as it leaves the pixel stage (same-entry bypass
//  in the memory); the single memory port pair sets the rate. A frame-last item
//  and, if the frame summed any pixels, the mean divider hold off new items.
//  Reset is synchronous; the frame memory needs no clearing, the first frame
//  fills it. Output stalls hold the result register and, once the pixel stage
//  is full, the input.
// ----------------------------------------------------------------------------
module adaptive_background_motion_detect #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  abmd_pixel_if.sink     in_px,
  abmd_result_if.source  out_res,
  abmd_cfg_if.sink       cfg_wr
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(FRAME_WIDTH);

  // configuration
  logic [abmd_pkg::GAIN_W-1:0]   gain_r;
  logic [abmd_pkg::RATE_W-1:0]   rate_r;
  logic [abmd_pkg::MOTION_W-1:0] min_r;

  // frame state
  logic                          bg_valid_r;
  logic [abmd_pkg::LUM_W-1:0]    lum_r;
  logic [abmd_pkg::COUNT_W-1:0]  cnt_r;
  logic [abmd_pkg::MOTION_W-1:0] mot_r;
  logic [abmd_pkg::MEAN_W-1:0]   ambient_r;
  logic [abmd_pkg::LIMIT_W-1:0]  limit_r;

  // pixel stage
  logic                          s1_valid_r;
  abmd_pkg::abmd_rgb_t           s1_pix_r;
  logic [abmd_pkg::X_W-1:0]      s1_x_r;
  logic [abmd_pkg::Y_W-1:0]      s1_y_r;
  logic                          s1_last_r;
  logic                          s1_inside_r;
  logic [ADDR_W-1:0]             s1_addr_r;

  // result register
  logic                          out_valid_r;
  logic                          out_moving_r;
  logic [abmd_pkg::X_W-1:0]      out_x_r;
  logic [abmd_pkg::Y_W-1:0]      out_y_r;
  logic                          out_done_r;
  logic                          out_enough_r;
  logic [abmd_pkg::MOTION_W-1:0] out_total_r;
  logic [abmd_pkg::MEAN_W-1:0]   out_mean_r;

  logic                          in_fire;
  logic                          in_inside;
  logic [ADDR_W-1:0]             in_addr;
  abmd_pkg::abmd_rgb_t           in_pix;
  logic                          out_free;
  logic                          s1_fire;
  abmd_pkg::abmd_rgb_t           bg;
  abmd_pkg::abmd_rgb_t           bg_nxt;
  abmd_pkg::abmd_rgb_t           wr_pix;
  logic                          wr_en;
  logic [abmd_pkg::DIST_W-1:0]   diff_sum;
  logic [abmd_pkg::DIST_W-1:0]   lum_add;
  logic                          counted;
  logic                          moving;
  logic [abmd_pkg::LUM_W:0]      lum_sum;
  logic [abmd_pkg::LUM_W-1:0]    lum_nxt;
  logic [abmd_pkg::COUNT_W-1:0]  cnt_nxt;
  logic [abmd_pkg::MOTION_W-1:0] mot_nxt;
  logic                          enough;
  abmd_pkg::abmd_div_req_t       div_req;
  abmd_pkg::abmd_div_st_t        div_st;

  // ---------------------------------------------------------------- config
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= abmd_pkg::GAIN_RESET;
      rate_r <= abmd_pkg::RATE_RESET;
      min_r  <= abmd_pkg::MIN_MOTION_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        abmd_pkg::CFG_THRESHOLD_GAIN:    gain_r <= cfg_wr.data[abmd_pkg::GAIN_W-1:0];
        abmd_pkg::CFG_LEARN_RATE:        rate_r <= cfg_wr.data[abmd_pkg::RATE_W-1:0];
        abmd_pkg::CFG_MIN_MOTION_PIXELS: min_r  <= cfg_wr.data[abmd_pkg::MOTION_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= abmd_pkg::LIMIT_W'(gain_r) * abmd_pkg::LIMIT_W'(ambient_r);
  end

  // ---------------------------------------------------------------- input
  assign out_free = (!out_valid_r || out_res.ready) && !div_st.busy;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_px.ready = !div_st.busy && !(s1_valid_r && s1_last_r) &&
                       (!s1_valid_r || out_free);
  assign in_fire  = in_px.valid && in_px.ready;

  always_comb begin
    in_inside = (32'(in_px.pixel_x) < FRAME_WIDTH) && (32'(in_px.pixel_y) < FRAME_HEIGHT);
    in_addr   = ADDR_W'(in_px.pixel_y) * ROW_STRIDE + ADDR_W'(in_px.pixel_x);
    in_pix.r  = in_px.red;
    in_pix.g  = in_px.green;
    in_pix.b  = in_px.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r    <= in_pix;
      s1_x_r      <= in_px.pixel_x;
      s1_y_r      <= in_px.pixel_y;
      s1_last_r   <= in_px.frame_last;
      s1_inside_r <= in_inside;
      s1_addr_r   <= in_addr;
    end
  end

  // ---------------------------------------------------------------- store
  abmd_store #(
    .DEPTH  (PIXELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (in_fire && in_inside),
    .rd_addr (in_addr),
    .rd_data (bg),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_pix)
  );

  // ---------------------------------------------------------------- judge
  always_comb begin
    diff_sum = abmd_pkg::DIST_W'(abmd_pkg::abs_diff(s1_pix_r.r, bg.r)) +
               abmd_pkg::DIST_W'(abmd_pkg::abs_diff(s1_pix_r.g, bg.g)) +
               abmd_pkg::DIST_W'(abmd_pkg::abs_diff(s1_pix_r.b, bg.b));
    lum_add = abmd_pkg::DIST_W'(s1_pix_r.r) + abmd_pkg::DIST_W'(s1_pix_r.g) +
              abmd_pkg::DIST_W'(s1_pix_r.b);
    bg_nxt.r = abmd_pkg::adapt_ch(bg.r, s1_pix_r.r, rate_r);
    bg_nxt.g = abmd_pkg::adapt_ch(bg.g, s1_pix_r.g, rate_r);
    bg_nxt.b = abmd_pkg::adapt_ch(bg.b, s1_pix_r.b, rate_r);
    wr_pix   = bg_valid_r ? bg_nxt : s1_pix_r;
    wr_en    = s1_fire && s1_inside_r;
    counted  = s1_inside_r && bg_valid_r;
    moving   = counted && (abmd_pkg::LIMIT_W'({diff_sum, 12'b0}) > limit_r);

    lum_sum  = {1'b0, lum_r} + (abmd_pkg::LUM_W+1)'(lum_add);
    if (!counted) begin
      lum_nxt = lum_r;
    end else if (lum_sum[abmd_pkg::LUM_W]) begin
      lum_nxt = abmd_pkg::LUM_MAX;
    end else begin
      lum_nxt = lum_sum[abmd_pkg::LUM_W-1:0];
    end
    cnt_nxt = (counted && (cnt_r != abmd_pkg::COUNT_MAX)) ? cnt_r + 1'b1 : cnt_r;
    mot_nxt = (moving && (mot_r != abmd_pkg::MOTION_MAX)) ? mot_r + 1'b1 : mot_r;
    enough  = s1_last_r && bg_valid_r && (mot_nxt > min_r);

    div_req.start    = s1_fire && s1_last_r && bg_valid_r && (cnt_nxt != '0);
    div_req.dividend = {lum_nxt, 4'b0};
    div_req.divisor  = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_valid_r <= 1'b0;
      lum_r      <= '0;
      cnt_r      <= '0;
      mot_r      <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        bg_valid_r <= 1'b1;
        lum_r      <= '0;
        cnt_r      <= '0;
        mot_r      <= '0;
      end else begin
        lum_r      <= lum_nxt;
        cnt_r      <= cnt_nxt;
        mot_r      <= mot_nxt;
      end
    end
  end

  abmd_mean_div u_mean_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .st    (div_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ambient_r <= '0;
    end else if (div_st.done) begin
      ambient_r <= div_st.mean;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= !div_req.start;
    end else if (div_st.done) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_moving_r <= moving;
      out_x_r      <= s1_x_r;
      out_y_r      <= s1_y_r;
      out_done_r   <= s1_last_r;
      out_enough_r <= enough;
      out_total_r  <= mot_nxt;
      out_mean_r   <= ambient_r;
    end else if (div_st.done) begin
      out_mean_r   <= div_st.mean;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.is_moving       = out_moving_r;
  assign out_res.out_x           = out_x_r;
  assign out_res.out_y           = out_y_r;
  assign out_res.frame_done      = out_done_r;
  assign out_res.enough_motion   = out_enough_r;
  assign out_res.moving_total    = out_total_r;
  assign out_res.mean_luminosity = out_mean_r;

  // ---------------------------------------------------------------- checks
  a_no_accept_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !in_px.ready)
    else $error("item taken while mean divider busy");

  a_result_held_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !out_valid_r)
    else $error("result shown before frame mean is ready");

  a_frame_end_sets_bg: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (bg_valid_r && (cnt_r == '0) && (mot_r == '0)))
    else $error("frame end did not clear sums or mark background");

  a_motion_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    abmd_pkg::COUNT_W'(mot_r) <= cnt_r)
    else $error("motion count exceeds pixel count");

endmodule
`default_nettype wire

>>> sv/abmd_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abmd_store
// Background frame memory, one RGB word per pixel, registered read with
// bypass of a write to the same entry at the same edge.
// ----------------------------------------------------------------------------
module abmd_store #(
  parameter int DEPTH  = 307200,
  parameter int ADDR_W = 19
) (
  input  wire logic                clk,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output abmd_pkg::abmd_rgb_t      rd_data,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire abmd_pkg::abmd_rgb_t wr_data
);

  abmd_pkg::abmd_rgb_t mem [DEPTH];
  abmd_pkg::abmd_rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> sv/abmd_mean_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abmd_mean_div
// Restoring divider for the frame mean luminosity, one quotient bit per
// cycle, saturating to the mean width.
// ----------------------------------------------------------------------------
module abmd_mean_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire abmd_pkg::abmd_div_req_t req,
  output abmd_pkg::abmd_div_st_t      st
);

  logic                                busy_r;
  logic                                sat_r;
  logic [abmd_pkg::STEP_W-1:0]         step_r;
  logic [abmd_pkg::DIVIDEND_W-1:0]     rem_r;
  logic [abmd_pkg::SHIFT_W-1:0]        sh_r;
  logic [abmd_pkg::MEAN_W-2:0]         quo_r;

  logic                                take;
  logic [abmd_pkg::MEAN_W-1:0]         quo_nxt;
  logic                                sat_nxt;
  logic                                last_step;

  always_comb begin
    take      = abmd_pkg::SHIFT_W'(rem_r) >= sh_r;
    quo_nxt   = {quo_r, take};
    last_step = busy_r && (step_r == '0);
    sat_nxt   = (abmd_pkg::SHIFT_W+1)'(req.dividend) >=
                {req.divisor, {abmd_pkg::MEAN_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (last_step) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sat_r  <= sat_nxt;
      step_r <= abmd_pkg::STEP_W'(abmd_pkg::MEAN_W - 1);
      rem_r  <= req.dividend;
      sh_r   <= {req.divisor, {(abmd_pkg::MEAN_W-1){1'b0}}};
      quo_r  <= '0;
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      sh_r   <= sh_r >> 1;
      quo_r  <= quo_nxt[abmd_pkg::MEAN_W-2:0];
      if (take) begin
        rem_r <= rem_r - sh_r[abmd_pkg::DIVIDEND_W-1:0];
      end
    end
  end

  assign st.busy = busy_r;
  assign st.done = last_step;
  assign st.mean = sat_r ? abmd_pkg::MEAN_MAX : quo_nxt;

endmodule
`default_nettype wire
